[src/pmd_pkg.sv]
// Shared types and constants for the PS/2 mouse packet decoder.
`default_nettype none

package pmd_pkg;

  localparam logic [7:0] STATUS_DATA_BIT = 8'h20;
  localparam int unsigned BUTTON_COUNT = 3;
  localparam int unsigned QUEUE_DEPTH = 2;  // power of two, pointers wrap
  localparam int unsigned QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [1:0] KIND_MOVE    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic [1:0]        button_number;
    logic              last_event;
  } evt_t;

  // One complete packet, reduced to what the event generator needs.
  typedef struct packed {
    logic                    has_move;
    logic [7:0]              x;
    logic [7:0]              neg_y;
    logic [BUTTON_COUNT-1:0] changed;
    logic [BUTTON_COUNT-1:0] was;
  } pkt_t;

endpackage

`default_nettype wire

[src/pmd_front.sv]
// Byte acceptance and packet assembly; pushes complete packets to the queue.
`default_nettype none

module pmd_front
  import pmd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  input  wire logic q_full,
  output logic      cmd_stall,
  output logic      q_push,
  output pkt_t      q_data
);

  logic [1:0]              byte_position;
  logic [7:0]              byte0;
  logic [7:0]              byte1;
  logic [BUTTON_COUNT-1:0] button_state;

  logic take;
  logic last_byte;
  pkt_t pkt;

  assign cmd_stall = q_full;
  assign take      = cmd_valid && !q_full && ((cmd.status_byte & STATUS_DATA_BIT) != 8'h00);
  assign last_byte = (byte_position == 2'd2);

  always_comb begin
    pkt.x        = byte1;
    pkt.neg_y    = 8'h00 - cmd.data_byte;
    pkt.has_move = (byte1 != 8'h00) || (cmd.data_byte != 8'h00);
    pkt.was      = button_state;
    pkt.changed  = byte0[BUTTON_COUNT-1:0] ^ button_state;
  end

  assign q_push = take && last_byte && (pkt.has_move || (pkt.changed != '0));
  assign q_data = pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 2'd0;
      button_state  <= '0;
    end else if (take) begin
      if (last_byte) begin
        byte_position <= 2'd0;
        button_state  <= byte0[BUTTON_COUNT-1:0];
      end else begin
        byte_position <= byte_position + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_position == 2'd0) begin
      byte0 <= cmd.data_byte;
    end
    if (take && byte_position == 2'd1) begin
      byte1 <= cmd.data_byte;
    end
  end

endmodule

`default_nettype wire

[src/pmd_queue.sv]
// Small packet queue between the front and the event generator.
`default_nettype none

module pmd_queue
  import pmd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire pkt_t push_data,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output pkt_t      head
);

  pkt_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/pmd_back.sv]
// Event generator: walks a packet's pending events into the output register.
`default_nettype none

module pmd_back
  import pmd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire pkt_t q_head,
  output logic      q_pop,
  input  wire logic evt_stall,
  output logic      evt_valid,
  output evt_t      evt
);

  // pend bit 0 = movement, bit i = button i
  logic                    active;
  logic [BUTTON_COUNT:0]   pend;
  logic [7:0]              cur_x;
  logic [7:0]              cur_ny;
  logic [BUTTON_COUNT-1:0] cur_was;

  logic                    out_free;
  logic                    emit;
  logic                    emit_last;
  logic [BUTTON_COUNT:0]   sel;
  logic [BUTTON_COUNT:0]   pend_after;
  evt_t                    nxt;

  assign out_free = !evt_valid || !evt_stall;
  assign emit     = active && out_free;

  always_comb begin
    sel = '0;
    for (int i = BUTTON_COUNT; i >= 0; i--) begin
      if (pend[i]) begin
        sel = '0;
        sel[i] = 1'b1;
      end
    end
  end

  assign pend_after = pend & ~sel;
  assign emit_last  = emit && (pend_after == '0);
  assign q_pop      = !q_empty && (!active || emit_last);

  always_comb begin
    nxt.event_kind    = KIND_MOVE;
    nxt.move_x        = cur_x;
    nxt.move_y        = cur_ny;
    nxt.button_number = 2'd0;
    nxt.last_event    = (pend_after == '0);
    for (int i = 1; i <= BUTTON_COUNT; i++) begin
      if (sel[i]) begin
        nxt.event_kind    = cur_was[i-1] ? KIND_RELEASE : KIND_PRESS;
        nxt.move_x        = 8'sd0;
        nxt.move_y        = 8'sd0;
        nxt.button_number = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= '0;
      evt_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        pend   <= {q_head.changed, q_head.has_move};
      end else if (emit) begin
        pend <= pend_after;
        if (emit_last) begin
          active <= 1'b0;
        end
      end
      if (out_free) begin
        evt_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_x   <= q_head.x;
      cur_ny  <= q_head.neg_y;
      cur_was <= q_head.was;
    end
    if (emit) begin
      evt <= nxt;
    end
  end

  a_active_has_work: assert property (@(posedge clk) disable iff (rst)
    active |-> (pend != '0))
    else $error("active packet with no pending events");

  a_pop_only_when_done: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!active || emit_last))
    else $error("packet popped while previous one still pending");

  a_move_no_button: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt.event_kind == KIND_MOVE) |-> (evt.button_number == 2'd0))
    else $error("movement event carries a button number");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (emit_last && !q_pop) |=> !active)
    else $error("generator still active after last event");

endmodule

`default_nettype wire

[src/ps2_mouse_packet_decoder.sv]
// Top level of the PS/2 mouse three-byte packet decoder.
// The first event of a packet passes the queue slot, the generator registers and the evt register.
// Throughput: one byte request per cycle unless cmd_stall; one event per cycle unless evt_stall.
// A packet of up to four events is drained by the generator one event per cycle unless stalled.
// Reset (rst, synchronous): byte position, button state, queue and output valid cleared.
// Packet bytes are not reset; a packet is only reported once all three are written.
`default_nettype none

module ps2_mouse_packet_decoder
  import pmd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  // byte requests from the controller side
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  // decoded mouse events
  output logic      evt_valid,
  input  wire logic evt_stall,
  output evt_t      evt
);

  // front -> queue
  logic q_push;
  pkt_t q_in;
  logic q_full;

  // queue -> back
  logic q_pop;
  logic q_empty;
  pkt_t q_head;

  // Front: filters on status bit 5, collects bytes, diffs the buttons and
  // pushes a packet summary when the packet produces at least one event.
  // It only stalls when the queue is full.
  pmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .q_full    (q_full),
    .cmd_stall (cmd_stall),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Queue decouples byte intake from event output backpressure.
  pmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: movement first, then buttons 1..3 in order, last one flagged.
  pmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .evt_stall (evt_stall),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

endmodule

`default_nettype wire
